// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/sha_pkg.sv =====
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       ends_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [6:0] LEN_POS     = 7'd56;
    localparam logic [6:0] LAST_BYTE   = 7'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [2:0] LAST_WORD   = 3'd7;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/sha_chan_if.sv =====
interface sha_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sha256_stream_hasher_top.sv =====
// a plain byte word is loaded into the block; one that fills a block starts the rounds and the fold
// ending a message: pad bytes at one per cycle, then rounds and fold per padded block (one or two),
// then 8 digest words, one per cycle while the sink is ready
// input is taken only while idle, not during rounds, fold, padding or digest output;
// the single round unit serves all 64 rounds of a block
// reset: synchronous active low; chain back to initial hash, counters clear, no pending work
`include "assert_macros.svh"

module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_chan_if.sink   i_in,
    sha_chan_if.source o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;

    // chaining value and working variables a..h
    logic [31:0] r_chain [8];
    logic [31:0] n_chain [8];
    logic [31:0] r_work  [8];
    logic [31:0] n_work  [8];

    // message block doubles as the schedule window, word 0 oldest
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];

    logic [60:0] r_count, n_count;
    logic [6:0]  r_fill, n_fill;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic        r_pad, n_pad;       // message is being finished
    logic        r_mark, n_mark;     // 0x80 already placed
    logic        r_lenblk, n_lenblk; // current block carries the bit length

    t_in_item    w_item;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_shift;
    logic [7:0]  w_byte;
    logic [63:0] w_len_bits;
    logic [7:0]  w_len_byte;
    logic [31:0] w_sched;
    logic [31:0] w_word;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign w_item    = i_in.payload;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc  = i_in.valid && i_in.ready;

    assign o_out.valid               = (r_state == ST_EMIT);
    assign o_out.payload.digest_word = r_chain[r_idx];
    assign o_out.payload.word_index  = r_idx;
    assign o_out.payload.last_word   = (r_idx == LAST_WORD);
    assign w_out_acc = o_out.valid && o_out.ready;

    // length bytes go out most significant first at fill 56..63
    assign w_len_bits = {r_count, 3'b000};
    assign w_len_byte = w_len_bits[{~r_fill[2:0], 3'b000} +: 8];

    // round unit: one sha-256 round per cycle
    assign w_sched = r_win[0] + sml_sig0(r_win[1]) + r_win[9] + sml_sig1(r_win[14]);
    assign w_word  = (r_round[5:4] == 2'b00) ? r_win[0] : w_sched;
    assign w_t1 = r_work[7] + big_sig1(r_work[4])
                + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
                + K_ROUND[r_round] + w_word;
    assign w_t2 = big_sig0(r_work[0])
                + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                ^ (r_work[1] & r_work[2]));

    always_comb begin
        n_state  = r_state;
        n_chain  = r_chain;
        n_work   = r_work;
        n_count  = r_count;
        n_fill   = r_fill;
        n_round  = r_round;
        n_idx    = r_idx;
        n_pad    = r_pad;
        n_mark   = r_mark;
        n_lenblk = r_lenblk;
        w_shift  = 1'b0;
        w_byte   = w_item.data_byte;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_item.has_byte) begin
                        w_shift = 1'b1;
                        n_fill  = r_fill + 7'd1;
                        n_count = r_count + 61'd1;
                    end
                    if (w_item.ends_message) begin
                        n_pad = 1'b1;
                    end
                    if (w_item.has_byte && r_fill == LAST_BYTE) begin
                        // block full: compress first, padding follows if ending
                        n_state = ST_ROUND;
                        n_fill  = '0;
                        n_work  = r_chain;
                    end else if (w_item.ends_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                w_shift = 1'b1;
                if (!r_mark) begin
                    w_byte   = PAD_MARK;
                    n_mark   = 1'b1;
                    n_lenblk = (r_fill < LEN_POS);
                end else if (r_lenblk && r_fill >= LEN_POS) begin
                    w_byte = w_len_byte;
                end else begin
                    w_byte = 8'h00;
                end
                n_fill = r_fill + 7'd1;
                if (r_fill == LAST_BYTE) begin
                    n_state = ST_ROUND;
                    n_fill  = '0;
                    n_work  = r_chain;
                end
            end
            ST_ROUND: begin
                n_work[0] = w_t1 + w_t2;
                n_work[1] = r_work[0];
                n_work[2] = r_work[1];
                n_work[3] = r_work[2];
                n_work[4] = r_work[3] + w_t1;
                n_work[5] = r_work[4];
                n_work[6] = r_work[5];
                n_work[7] = r_work[6];
                n_round   = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                    n_round = '0;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_work[i];
                end
                if (!r_pad) begin
                    n_state = ST_IDLE;
                end else if (r_lenblk) begin
                    n_state = ST_EMIT;
                    n_idx   = '0;
                end else begin
                    // mark not yet placed, or it left no room for the length: one more block
                    n_state = ST_PAD;
                    if (r_mark) begin
                        n_lenblk = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == LAST_WORD) begin
                        n_state  = ST_IDLE;
                        n_chain  = IV;
                        n_count  = '0;
                        n_fill   = '0;
                        n_pad    = 1'b0;
                        n_mark   = 1'b0;
                        n_lenblk = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // window: byte shift while loading, word rotate with new schedule word per round
    always_comb begin
        n_win = r_win;
        if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[15] = w_word;
        end else if (w_shift) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = {r_win[i][23:0], r_win[i + 1][31:24]};
            end
            n_win[15] = {r_win[15][23:0], w_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_work <= n_work;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= IV;
            r_count  <= '0;
            r_fill   <= '0;
            r_round  <= '0;
            r_idx    <= '0;
            r_pad    <= 1'b0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_pad    <= n_pad;
            r_mark   <= n_mark;
            r_lenblk <= n_lenblk;
        end
    end

    // never take input while a digest word is on offer
    `ASSERT_IMPLIES(a_excl_sides, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    // round counter rests at zero outside the rounds
    `ASSERT_IMPLIES(a_round_idle, i_clk, i_rst_n, r_state != ST_ROUND, r_round == '0)
    // digest only after the length block was placed
    `ASSERT_IMPLIES(a_emit_len, i_clk, i_rst_n, r_state == ST_EMIT, r_pad && r_mark && r_lenblk)
    // last word restarts the message
    `ASSERT_NEXT(a_restart, i_clk, i_rst_n, w_out_acc && o_out.payload.last_word,
        r_count == '0 && r_fill == '0 && i_in.ready)

endmodule

// ===== tb/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam int         LEN_FIELD_AT = 56;
    localparam int         BLOCK_LEN    = 64;

    localparam logic [31:0] START_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] chain [8];
    logic [60:0] msg_bytes;
    logic [7:0]  blk [64];
    int          fill;
    t_out_item   digest_due [$];
    t_out_item   want;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic void fold_block();
        logic [31:0] w [16];
        logic [31:0] r [8];
        logic [31:0] wt;
        logic [31:0] w15;
        logic [31:0] w2;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 0; i < 8; i++)
            r[i] = chain[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                // rolling 16-entry schedule window
                w15 = w[(t + 1) % 16];
                w2  = w[(t + 14) % 16];
                wt  = w[t % 16] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3))
                    + w[(t + 9) % 16] + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
                w[t % 16] = wt;
            end
            t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[t] + wt;
            t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6];
            r[6] = r[5];
            r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2];
            r[2] = r[1];
            r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + r[i];
    endfunction

    function automatic void start_message();
        for (int i = 0; i < 8; i++)
            chain[i] = START_CHAIN[i];
        msg_bytes = '0;
        fill      = 0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        blk[fill] = b;
        fill++;
        msg_bytes = msg_bytes + 61'd1;
        if (fill == BLOCK_LEN) begin
            fold_block();
            fill = 0;
        end
    endfunction

    function automatic void close_message();
        logic [63:0] bit_len;
        t_out_item   w;
        blk[fill] = PAD_BYTE;
        fill++;
        // no room left for the length: spill into one more block
        if (fill > LEN_FIELD_AT) begin
            while (fill < BLOCK_LEN) begin
                blk[fill] = '0;
                fill++;
            end
            fold_block();
            fill = 0;
        end
        while (fill < LEN_FIELD_AT) begin
            blk[fill] = '0;
            fill++;
        end
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 8; i++)
            blk[LEN_FIELD_AT + i] = bit_len[63 - 8*i -: 8];
        fold_block();
        for (int i = 0; i < 8; i++) begin
            w.digest_word = chain[i];
            w.word_index  = 3'(i);
            w.last_word   = (i == 7);
            digest_due    = {digest_due, w};
        end
        start_message();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_message();
            digest_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: digest word with none due: expected nothing, actual %h/%0d/%0b",
                             $time, i_out_word.digest_word, i_out_word.word_index,
                             i_out_word.last_word);
                    o_fail_count++;
                end else begin
                    want = digest_due.pop_front();
                    check_field("digest_word", want.digest_word, i_out_word.digest_word);
                    check_field("word_index", 32'(want.word_index), 32'(i_out_word.word_index));
                    check_field("last_word", 32'(want.last_word), 32'(i_out_word.last_word));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_word.has_byte)
                    absorb_byte(i_in_word.data_byte);
                if (i_in_word.ends_message)
                    close_message();
            end
        end
        o_pending = digest_due.size();
    end

endmodule

// ===== tb/sha256_stream_hasher_top_tb.sv =====
`timescale 1ns / 1ps

module sha256_stream_hasher_top_tb
    import sha_pkg::*;
;

    // random words per idling phase, counting bytes and end words only
    localparam int RANDOM_WORDS_PER_PHASE = 6;
    // receiver hold-off long enough for the block to back up into its input
    localparam int HOLD_CYCLES  = 400;
    // settle time after the last digest
    localparam int DRAIN_CYCLES = 200;
    // watchdog limit; keep a wide margin over the longest run
    localparam int LIMIT_CYCLES = 300000;
    localparam int HEAVY_PCT    = 73;
    localparam int LIGHT_PCT    = 8;
    localparam int NOISE_PCT    = 5;

    logic clk;
    logic rst_n;

    // idling knobs, written by the stimulus process only
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_reqs     = 0;

    int words_sent  = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    sha_chan_if #(.t_payload(t_in_item))  in_ch ();
    sha_chan_if #(.t_payload(t_out_item)) out_ch ();

    sha256_stream_hasher_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicts digests from accepted words and checks every result word
    sha256_digest_checker digest_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_word    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_word   (out_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request,
    // counted here so the sender keeps pushing meanwhile
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (hold_seen != hold_reqs) begin
                hold_seen    = hold_reqs;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one word; entered and left at a falling edge
    task automatic send_word(input logic [7:0] d, input logic has_b, input logic ends);
        // random gap before the word
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid                = 1'b1;
        in_ch.payload.data_byte    = d;
        in_ch.payload.has_byte     = has_b;
        in_ch.payload.ends_message = ends;
        forever begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        @(negedge clk);
    endtask

    // one message of random bytes; the end rides on the last byte or on a word of its own
    task automatic send_message(input int len, input bit end_on_last);
        for (int i = 0; i < len; i++) begin
            // stray word with neither flag, ignored by the block
            if ($urandom_range(99) < NOISE_PCT)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(255)), 1'b1, end_on_last && (i == len - 1));
            words_sent++;
        end
        if (!(end_on_last && len > 0)) begin
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
            words_sent++;
        end
    endtask

    // short random messages, empty ones included
    function automatic int pick_len();
        return $urandom_range(8);
    endfunction

    // sender pause: nothing offered until every digest word is out
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial begin : stimulus
        int target;
        int len;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, no idling
        // empty message
        send_word(8'h5a, 1'b0, 1'b1);
        // neither flag: no effect, data ignored
        send_word(8'hff, 1'b0, 1'b0);
        // lowest byte with the end in the same word
        send_word(8'h00, 1'b1, 1'b1);
        // highest byte, end on a word of its own
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // "abc", end word carries an ignored byte
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        // a byte equal to the pad mark, ending in the same word
        send_word(8'h80, 1'b1, 1'b1);
        // two empty messages back to back
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'ha5, 1'b0, 1'b1);
        // full block with the end on its last byte: fold first, then a padding-only block
        send_message(64, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = HEAVY_PCT;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = HEAVY_PCT;
                end
                default: begin
                    send_idle_pct = LIGHT_PCT;
                    stall_pct     = LIGHT_PCT;
                end
            endcase
            target = words_sent + RANDOM_WORDS_PER_PHASE;

            // back-pressure: receiver holds off while several messages pile in
            if (ph == 0) begin
                hold_reqs++;
                repeat (3) send_message($urandom_range(6, 1), 1'($urandom_range(1)));
            end

            while (words_sent < target) begin
                len = pick_len();
                if (len > target - words_sent)
                    len = target - words_sent;
                send_message(len, 1'($urandom_range(1)));
            end

            wait_drained();
        end

        // settle before the final check of failures and pending digest words
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
